/* sv/lfg_pkg.sv */
// ----------------------------------------------------------------------------
// lfg_pkg
// Shared widths, register codes and reset values of the lagged Fibonacci
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

    localparam int MAX_LAG    = 1024;
    localparam int POS_W      = 11;
    localparam int ADDR_W     = $clog2(MAX_LAG);
    localparam int WORD_W     = 64;
    localparam int OUT_W      = 32;
    localparam int SHORT_W    = 10;
    localparam int CFG_W      = 11;
    localparam int IN_DATA_W  = 80;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [OUT_W-1:0]   rword_t;
    typedef logic [SHORT_W-1:0] short_lag_t;

    typedef enum logic [1:0] {
        CFG_LAG_LONG  = 2'd0,
        CFG_LAG_SHORT = 2'd1,
        CFG_ADD_MODE  = 2'd2
    } cfg_idx_t;

    localparam logic FUNC_GEN  = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam pos_t       LAG_LONG_RST  = POS_W'(607);
    localparam short_lag_t LAG_SHORT_RST = SHORT_W'(273);
    localparam pos_t       SHORT_POS_RST = POS_W'(273);

endpackage

`default_nettype wire

/* sv/lagged_fibonacci_generator.sv */
// ----------------------------------------------------------------------------
// lagged_fibonacci_generator
// Lagged Fibonacci generator over a ring of 64-bit words held in block
// memory, add or subtract mode, streaming in and out.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one 32-bit word per generate
// request via the compute stage and output buffer; a load request (tuser = 1)
// writes one seed word and returns nothing. The ring sits in two copies of a
// 1024 x 64 synchronous memory, one per read lag, so both lagged words are
// read in the same cycle; the new word is written back in the following
// cycle and forwarded to the next request when its read hits that entry.
// Results queue in a four-entry output buffer, so requests keep flowing as
// long as the sink takes a word per cycle. The ring has no reset: positions
// lag_long down to 1 must be loaded before the first generate request.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none

module lagged_fibonacci_generator
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [lfg_pkg::CFG_W-1:0]      cfg_data,

    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // [10:0] load_position, [74:11] seed_word, [79:75] zero
    input  wire logic [lfg_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] func
    input  wire logic                           s_tuser,

    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] random_word
    output      logic [lfg_pkg::OUT_W-1:0]      m_tdata
);

    // configuration
    lfg_pkg::pos_t       lag_long_reg;
    lfg_pkg::short_lag_t lag_short_reg;
    logic                add_mode_reg;

    lfg_pkg::pos_t       eff_long;
    lfg_pkg::pos_t       eff_short;

    // read positions
    lfg_pkg::pos_t       long_pos_reg,  long_pos_next;
    lfg_pkg::pos_t       short_pos_reg, short_pos_next;
    lfg_pkg::pos_t       cur_i;
    lfg_pkg::pos_t       cur_j;
    lfg_pkg::addr_t      rd_addr_i;
    lfg_pkg::addr_t      rd_addr_j;

    // input decode
    logic                in_accept;
    logic                in_load;
    lfg_pkg::pos_t       in_pos;
    lfg_pkg::word_t      in_seed;
    logic                in_pos_ok;

    // memories
    lfg_pkg::word_t      ring_a [lfg_pkg::MAX_LAG];
    lfg_pkg::word_t      ring_b [lfg_pkg::MAX_LAG];
    lfg_pkg::word_t      rd_long_q;
    lfg_pkg::word_t      rd_short_q;

    // compute stage
    logic                s1_valid_reg;
    logic                s1_load_reg;
    logic                s1_wen_reg;
    lfg_pkg::addr_t      s1_addr_i_reg;
    lfg_pkg::addr_t      s1_addr_j_reg;
    lfg_pkg::word_t      s1_seed_reg;

    lfg_pkg::word_t      word_long;
    lfg_pkg::word_t      word_short;
    lfg_pkg::word_t      new_word;
    logic                mem_we;
    lfg_pkg::word_t      mem_wdata;
    logic                gen_pending;

    // last write, for forwarding
    logic                wr_valid_reg;
    lfg_pkg::addr_t      wr_addr_reg;
    lfg_pkg::word_t      wr_data_reg;

    // output buffer
    lfg_pkg::rword_t                 out_buf_reg [lfg_pkg::OUT_DEPTH];
    logic [lfg_pkg::OUT_PTR_W-1:0]   out_wr_ptr_reg;
    logic [lfg_pkg::OUT_PTR_W-1:0]   out_rd_ptr_reg;
    logic [lfg_pkg::OUT_CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic                            out_push;
    logic                            out_pop;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_long_reg  <= lfg_pkg::LAG_LONG_RST;
            lag_short_reg <= lfg_pkg::LAG_SHORT_RST;
            add_mode_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lfg_pkg::CFG_LAG_LONG:  lag_long_reg  <= cfg_data;
                lfg_pkg::CFG_LAG_SHORT: lag_short_reg <= cfg_data[lfg_pkg::SHORT_W-1:0];
                lfg_pkg::CFG_ADD_MODE:  add_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // lags saturated into their legal ranges
    always_comb
    begin
        if (lag_long_reg == '0)
            eff_long = lfg_pkg::POS_W'(1);
        else if (lag_long_reg > lfg_pkg::POS_W'(lfg_pkg::MAX_LAG))
            eff_long = lfg_pkg::POS_W'(lfg_pkg::MAX_LAG);
        else
            eff_long = lag_long_reg;

        if (lag_short_reg == '0)
            eff_short = lfg_pkg::POS_W'(1);
        else if (lfg_pkg::POS_W'(lag_short_reg) > eff_long)
            eff_short = eff_long;
        else
            eff_short = lfg_pkg::POS_W'(lag_short_reg);
    end

    // ------------------------------------------------------------------
    // request side: positions and memory reads
    // ------------------------------------------------------------------
    assign in_accept = s_tvalid && s_tready;
    assign in_load   = (s_tuser == lfg_pkg::FUNC_LOAD);
    assign in_pos    = s_tdata[lfg_pkg::POS_W-1:0];
    assign in_seed   = s_tdata[lfg_pkg::POS_W +: lfg_pkg::WORD_W];
    assign in_pos_ok = (in_pos != '0) && (in_pos <= lfg_pkg::POS_W'(lfg_pkg::MAX_LAG));

    always_comb
    begin
        cur_i = long_pos_reg;
        cur_j = short_pos_reg;
        if (long_pos_reg == '0 || long_pos_reg > lfg_pkg::POS_W'(lfg_pkg::MAX_LAG))
            cur_i = eff_long;
        if (short_pos_reg == '0 || short_pos_reg > lfg_pkg::POS_W'(lfg_pkg::MAX_LAG))
            cur_j = eff_long;
    end

    assign rd_addr_i = lfg_pkg::ADDR_W'(cur_i - lfg_pkg::POS_W'(1));
    assign rd_addr_j = lfg_pkg::ADDR_W'(cur_j - lfg_pkg::POS_W'(1));

    always_comb
    begin
        long_pos_next  = long_pos_reg;
        short_pos_next = short_pos_reg;
        if (in_accept)
        begin
            if (in_load)
            begin
                long_pos_next  = eff_long;
                short_pos_next = eff_short;
            end
            else
            begin
                long_pos_next  = (cur_i <= lfg_pkg::POS_W'(1)) ? eff_long
                                                               : cur_i - lfg_pkg::POS_W'(1);
                short_pos_next = (cur_j <= lfg_pkg::POS_W'(1)) ? eff_long
                                                               : cur_j - lfg_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_pos_reg  <= lfg_pkg::LAG_LONG_RST;
            short_pos_reg <= lfg_pkg::SHORT_POS_RST;
        end
        else
        begin
            long_pos_reg  <= long_pos_next;
            short_pos_reg <= short_pos_next;
        end
    end

    // one copy per read lag, both written alike
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_a[s1_addr_i_reg] <= mem_wdata;
        rd_long_q <= ring_a[rd_addr_i];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_b[s1_addr_i_reg] <= mem_wdata;
        rd_short_q <= ring_b[rd_addr_j];
    end

    // ------------------------------------------------------------------
    // compute stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_load_reg  <= 1'b0;
            s1_wen_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s1_load_reg  <= in_load;
            s1_wen_reg   <= in_load ? in_pos_ok : 1'b1;
        end
    end

    // a load carries its write address in the long address slot
    always_ff @(posedge clk)
    begin
        s1_addr_i_reg <= in_load ? lfg_pkg::ADDR_W'(in_pos - lfg_pkg::POS_W'(1)) : rd_addr_i;
        s1_addr_j_reg <= rd_addr_j;
        s1_seed_reg   <= in_seed;
    end

    // the read was sampled on the same edge as the previous write
    assign word_long  = (wr_valid_reg && wr_addr_reg == s1_addr_i_reg) ? wr_data_reg : rd_long_q;
    assign word_short = (wr_valid_reg && wr_addr_reg == s1_addr_j_reg) ? wr_data_reg : rd_short_q;
    assign new_word   = add_mode_reg ? word_long + word_short : word_long - word_short;

    assign mem_we      = s1_valid_reg && s1_wen_reg;
    assign mem_wdata   = s1_load_reg ? s1_seed_reg : new_word;
    assign gen_pending = s1_valid_reg && !s1_load_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else if (mem_we)
            wr_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wr_addr_reg <= s1_addr_i_reg;
            wr_data_reg <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------
    assign out_push = gen_pending;
    assign out_pop  = m_tvalid && m_tready;
    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tdata  = out_buf_reg[out_rd_ptr_reg];

    // room must be reserved for the word still in the compute stage
    assign s_tready = (out_cnt_reg + lfg_pkg::OUT_CNT_W'(gen_pending))
                      < lfg_pkg::OUT_CNT_W'(lfg_pkg::OUT_DEPTH);

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (out_push && !out_pop)
            out_cnt_next = out_cnt_reg + lfg_pkg::OUT_CNT_W'(1);
        else if (!out_push && out_pop)
            out_cnt_next = out_cnt_reg - lfg_pkg::OUT_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg    <= '0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (out_push)
                out_wr_ptr_reg <= out_wr_ptr_reg + lfg_pkg::OUT_PTR_W'(1);
            if (out_pop)
                out_rd_ptr_reg <= out_rd_ptr_reg + lfg_pkg::OUT_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            out_buf_reg[out_wr_ptr_reg] <= new_word[lfg_pkg::WORD_W-1 -: lfg_pkg::OUT_W];
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_buf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= lfg_pkg::OUT_CNT_W'(lfg_pkg::OUT_DEPTH))
        else $error("output buffer overflow");

    a_push_from_gen: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !in_load |=> out_push)
        else $error("generate request lost its result");

    a_load_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_load |=> !out_push)
        else $error("load request produced a result");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        long_pos_reg != '0 && long_pos_reg <= lfg_pkg::POS_W'(lfg_pkg::MAX_LAG)
        && short_pos_reg != '0 && short_pos_reg <= lfg_pkg::POS_W'(lfg_pkg::MAX_LAG))
        else $error("read position out of ring");

endmodule

`default_nettype wire
